// ===== src/lvpl_pkg.sv =====
// Shared constants, types and state encoding for the layered velocity lookup.
`timescale 1ns / 1ps
package lvpl_pkg;

    localparam int MAX_LAYERS = 64;
    localparam int AW         = $clog2(MAX_LAYERS);
    localparam int TH_W       = 20;
    localparam int V_W        = 14;
    localparam int RHO_W      = 13;
    localparam int D_W        = 21;
    localparam int CUM_W      = TH_W + AW + 1;
    localparam int CNT_W      = 7;
    localparam int ENTRY_W    = TH_W + V_W + V_W + RHO_W;
    localparam int PROD_W     = V_W + TH_W;
    localparam int DIV_STEPS  = V_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
    localparam int IN_W       = 112;
    localparam int OUT_W      = 48;

    localparam logic CFG_LAYER_COUNT = 1'b0;
    localparam logic CFG_INTERP_MODE = 1'b1;
    localparam logic OP_LOAD         = 1'b0;
    localparam logic OP_QUERY        = 1'b1;

    localparam logic [1:0] CH_VP  = 2'd0;
    localparam logic [1:0] CH_VS  = 2'd1;
    localparam logic [1:0] CH_RHO = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_we;
        logic step;
        logic hit;
        logic mul;
        logic div_step;
        logic div_fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_load;
        logic in_early;
        logic found;
        logic at_end;
        logic do_interp;
        logic div_done;
        logic chan_last;
        logic out_free;
    } t_status;

endpackage

// ===== src/lvpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lvpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/lvpl_ctrl.sv =====
// Controller: sequences load, layer walk, interpolation divide and output.
`timescale 1ns / 1ps
module lvpl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lvpl_pkg::t_status i_status,
    output lvpl_pkg::t_cmd    o_cmd,
    output logic              o_in_ready
);
    import lvpl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_load) begin
                        o_cmd.load_we = 1'b1;
                    end else if (i_status.in_early) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (i_status.found || i_status.at_end) begin
                    o_cmd.hit = 1'b1;
                    n_state   = i_status.do_interp ? S_MUL : S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.div_fin = 1'b1;
                    n_state       = i_status.chan_last ? S_DONE : S_MUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== src/lvpl_datapath.sv =====
// Datapath: layer table, running depth sum, multiply and restoring divider.
`timescale 1ns / 1ps
module lvpl_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [lvpl_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic [lvpl_pkg::IN_W-1:0]     i_in_data,
    input  logic                          i_in_op,
    input  logic                          i_in_last,
    input  logic                          i_out_ready,
    input  lvpl_pkg::t_cmd                i_cmd,
    output lvpl_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic [lvpl_pkg::OUT_W-1:0]    o_out_data
);
    import lvpl_pkg::*;

    // input word fields
    logic [AW-1:0]    in_idx;
    logic [TH_W-1:0]  in_th;
    logic [V_W-1:0]   in_vp, in_vs;
    logic [RHO_W-1:0] in_rho;
    logic [D_W-1:0]   in_depth, in_shift;
    logic             in_af, in_dom;
    logic [D_W:0]     d_sum;

    assign in_idx   = i_in_data[AW-1:0];
    assign in_th    = i_in_data[25:6];
    assign in_vp    = i_in_data[39:26];
    assign in_vs    = i_in_data[53:40];
    assign in_rho   = i_in_data[66:54];
    assign in_depth = i_in_data[87:67];
    assign in_shift = i_in_data[108:88];
    assign in_af    = i_in_data[109];
    assign in_dom   = i_in_data[110];
    assign d_sum    = {in_depth[D_W-1], in_depth} + {in_shift[D_W-1], in_shift};

    logic [CNT_W-1:0] r_layer_count;
    logic             r_interp;
    logic [AW-1:0]    last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= CNT_W'(1);
            r_interp      <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LAYER_COUNT) begin
                r_layer_count <= i_cfg_data;
            end else begin
                r_interp <= i_cfg_data[0];
            end
        end
    end

    always_comb begin
        if (r_layer_count == '0) begin
            last_idx = '0;
        end else if (r_layer_count > CNT_W'(MAX_LAYERS)) begin
            last_idx = AW'(MAX_LAYERS - 1);
        end else begin
            last_idx = AW'(r_layer_count - CNT_W'(1));
        end
    end

    // layer table
    logic [AW-1:0]      r_i;
    logic [ENTRY_W-1:0] rd_entry;
    logic [TH_W-1:0]    e_th;
    logic [V_W-1:0]     e_v [3];

    lvpl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LAYERS)) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (in_idx),
        .i_wdata ({in_rho, in_vs, in_vp, in_th}),
        .i_raddr (r_i),
        .o_rdata (rd_entry)
    );

    assign e_th   = rd_entry[TH_W-1:0];
    assign e_v[0] = rd_entry[TH_W+V_W-1:TH_W];
    assign e_v[1] = rd_entry[TH_W+2*V_W-1:TH_W+V_W];
    assign e_v[2] = {1'b0, rd_entry[ENTRY_W-1:TH_W+2*V_W]};

    // walk and interpolation state
    logic [D_W-1:0]   r_d;
    logic [CUM_W-1:0] r_cum;
    logic [TH_W-1:0]  r_th;
    logic [V_W-1:0]   r_prev [3];
    logic [V_W-1:0]   r_cur  [3];
    logic [V_W-1:0]   r_res  [3];
    logic [1:0]       r_chan;
    logic [PROD_W-1:0] r_prod;
    logic             r_neg;
    logic [TH_W-1:0]  r_rem;
    logic [V_W-1:0]   r_low;
    logic [V_W-1:0]   r_q;
    logic [DCNT_W-1:0] r_dcnt;
    logic             r_filled, r_pg, r_last, r_gap_seen;
    logic             r_ovalid;
    logic [V_W-1:0]   r_ovp, r_ovs;
    logic [RHO_W-1:0] r_orho;
    logic             r_ofilled, r_opg, r_obgap;

    logic [CUM_W-1:0] cum_next;
    logic             found;
    logic [CUM_W-1:0] off_full;
    logic [V_W-1:0]   lo, hi, mag;
    logic [TH_W:0]    trial;
    logic             q_bit;
    logic [V_W:0]     interp_val;
    logic             pg_final;

    assign cum_next = r_cum + CUM_W'(e_th);
    assign found    = cum_next > CUM_W'(r_d);
    assign off_full = CUM_W'(r_d) - r_cum;
    assign lo       = r_prev[r_chan];
    assign hi       = r_cur[r_chan];
    assign mag      = (hi >= lo) ? (hi - lo) : (lo - hi);
    assign trial    = {r_rem, r_low[V_W-1]};
    assign q_bit    = trial >= {1'b0, r_th};
    assign interp_val = r_neg ? ({1'b0, lo} - {1'b0, r_q}) : ({1'b0, lo} + {1'b0, r_q});
    assign pg_final = r_pg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_d     <= d_sum[D_W-1:0];
            r_cum   <= '0;
            r_last  <= i_in_last;
            r_res[0] <= '0;
            r_res[1] <= '0;
            r_res[2] <= '0;
            // negative depth, off-domain or already filled: no table walk
            r_filled <= !(in_af || !in_dom || d_sum[D_W]);
            r_pg     <= !in_af && (!in_dom || d_sum[D_W]);
        end
        if (i_cmd.step) begin
            r_cum <= cum_next;
            for (int c = 0; c < 3; c++) r_prev[c] <= e_v[c];
        end
        if (i_cmd.hit) begin
            r_th   <= e_th;
            r_chan <= CH_VP;
            for (int c = 0; c < 3; c++) begin
                r_cur[c] <= e_v[c];
                r_res[c] <= e_v[c];
            end
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(mag) * PROD_W'(off_full[TH_W-1:0]);
            r_neg  <= hi < lo;
        end
        if (i_cmd.div_step) begin
            if (r_dcnt == '0) begin
                // remainder starts below the divisor since offset < thickness
                r_rem <= r_prod[PROD_W-1:V_W];
                r_low <= r_prod[V_W-1:0];
                r_q   <= '0;
            end else begin
                r_rem <= q_bit ? TH_W'(trial - {1'b0, r_th}) : trial[TH_W-1:0];
                r_low <= {r_low[V_W-2:0], 1'b0};
                r_q   <= {r_q[V_W-2:0], q_bit};
            end
        end
        if (i_cmd.div_fin) begin
            r_res[r_chan] <= interp_val[V_W-1:0];
            r_chan        <= r_chan + 2'd1;
        end
        if (i_cmd.out_load) begin
            r_ovp     <= r_res[0];
            r_ovs     <= r_res[1];
            r_orho    <= r_res[2][RHO_W-1:0];
            r_ofilled <= r_filled;
            r_opg     <= pg_final;
            r_obgap   <= r_last && (r_gap_seen || pg_final);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i        <= '0;
            r_dcnt     <= '0;
            r_gap_seen <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_i <= '0;
            end else if (i_cmd.step) begin
                r_i <= r_i + AW'(1);
            end
            if (i_cmd.div_fin) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_gap_seen <= r_last ? 1'b0 : (r_gap_seen || pg_final);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status           = '0;
        o_status.in_valid  = i_in_valid;
        o_status.in_load   = i_in_op == OP_LOAD;
        o_status.in_early  = in_af || !in_dom || d_sum[D_W];
        o_status.found     = found;
        o_status.at_end    = r_i == last_idx;
        o_status.do_interp = found && (r_i != last_idx) && (r_i != '0) && r_interp;
        o_status.div_done  = r_dcnt == DCNT_W'(DIV_STEPS + 1);
        o_status.chan_last = r_chan == CH_RHO;
        o_status.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {4'b0, r_obgap, r_opg, r_ofilled, r_orho, r_ovs, r_ovp};
endmodule

// ===== src/layered_velocity_profile_lookup.sv =====
// Top level of the layered velocity profile lookup: controller plus datapath.
//
//  channel  | direction | signals                         | word accepted when
//  s_axis   | in        | tvalid tready tdata tuser tlast | tvalid && tready
//  m_axis   | out       | tvalid tready tdata             | tvalid && tready
//  cfg      | in        | i_cfg_we i_cfg_index i_cfg_data | i_cfg_we
//
// A load word is written into the table from idle. A query walks the table one
// layer at a time (RAM read, then compare); when interpolating, each of the
// three values takes a multiply, then the restoring divide; last the output
// register is loaded. Reset is synchronous and clears control and the batch
// gap flag; the table holds no reset. A result waiting on m_axis does not
// block a new word.
`timescale 1ns / 1ps
module layered_velocity_profile_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [lvpl_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // layer_index, layer_thickness, layer_vp, layer_vs, layer_rho, depth,
    // depth_shift, already_filled, in_crust_domain
    input  logic [lvpl_pkg::IN_W-1:0]     s_axis_tdata,
    input  logic                          s_axis_tuser,   // op
    input  logic                          s_axis_tlast,   // last_point
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_vp, out_vs, out_rho, filled, point_gap, batch_gap
    output logic [lvpl_pkg::OUT_W-1:0]    m_axis_tdata
);
    import lvpl_pkg::*;

    t_cmd    cmd;
    t_status status;

    lvpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    lvpl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );
endmodule

// ===== src/lvpl_checker.sv =====
// Port-level checker for the layered velocity lookup, bound to the top level.
`timescale 1ns / 1ps
module lvpl_assert (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [lvpl_pkg::OUT_W-1:0] m_axis_tdata
);
    import lvpl_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[41] |-> m_axis_tdata[40:0] == '0)
        else $error("unfilled point carries values");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[41] && m_axis_tdata[42]))
        else $error("point both filled and gapped");
endmodule

bind layered_velocity_profile_lookup lvpl_assert u_lvpl_assert (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/lvpl_checker.sv =====
// Checker for the layered velocity lookup: mirrors the table and compares every result word.
`timescale 1ns / 1ps
module lvpl_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [lvpl_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [lvpl_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                         i_s_tuser,
    input  logic                         i_s_tlast,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [lvpl_pkg::OUT_W-1:0]   i_m_tdata,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_results
);
    import lvpl_pkg::*;

    typedef struct packed {
        logic [V_W-1:0]   vp;
        logic [V_W-1:0]   vs;
        logic [RHO_W-1:0] rho;
        logic             filled;
        logic             point_gap;
        logic             batch_gap;
    } t_point;

    logic [TH_W-1:0]  thick_mem [MAX_LAYERS];
    logic [V_W-1:0]   vp_mem    [MAX_LAYERS];
    logic [V_W-1:0]   vs_mem    [MAX_LAYERS];
    logic [RHO_W-1:0] rho_mem   [MAX_LAYERS];
    logic             gap_seen;
    logic [CNT_W-1:0] layer_count;
    logic             interp_mode;
    t_point           expected_q [$];

    function automatic longint blend(longint lo, longint hi, longint off, longint th);
        return lo + ((hi - lo) * off) / th;
    endfunction

    // Lookup of one query word; updates the batch gap flag.
    function automatic t_point lookup_point(logic [IN_W-1:0] w, logic last);
        t_point r;
        longint d;
        longint cum;
        int     n;
        int     i;
        int     k;
        bit     found;
        r = '0;
        cum = 0;
        found = 0;
        if (!w[109]) begin
            d = longint'($signed(w[87:67])) + longint'($signed(w[108:88]));
            if (!w[110] || d < 0) begin
                r.point_gap = 1'b1;
            end else begin
                n = (layer_count == 0) ? 1 : int'(layer_count);
                if (n > MAX_LAYERS) n = MAX_LAYERS;
                for (i = 0; i < n; i++) begin
                    if (cum + longint'(thick_mem[i]) > d) begin
                        found = 1;
                        break;
                    end
                    cum += longint'(thick_mem[i]);
                end
                if (!found || i == n - 1 || i == 0 || !interp_mode) begin
                    k = found ? i : n - 1;
                    r.vp  = vp_mem[k];
                    r.vs  = vs_mem[k];
                    r.rho = rho_mem[k];
                end else begin
                    r.vp  = V_W'(blend(vp_mem[i-1], vp_mem[i], d - cum, thick_mem[i]));
                    r.vs  = V_W'(blend(vs_mem[i-1], vs_mem[i], d - cum, thick_mem[i]));
                    r.rho = RHO_W'(blend(rho_mem[i-1], rho_mem[i], d - cum, thick_mem[i]));
                end
                r.filled = 1'b1;
            end
        end
        if (r.point_gap) gap_seen = 1'b1;
        if (last) begin
            r.batch_gap = gap_seen;
            gap_seen = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (!i_rst_n) begin
            gap_seen    = 1'b0;
            layer_count = CNT_W'(1);
            interp_mode = 1'b0;
            expected_q.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LAYER_COUNT) layer_count = i_cfg_data;
                else interp_mode = i_cfg_data[0];
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_LOAD) begin
                    thick_mem[i_s_tdata[5:0]] = i_s_tdata[25:6];
                    vp_mem[i_s_tdata[5:0]]    = i_s_tdata[39:26];
                    vs_mem[i_s_tdata[5:0]]    = i_s_tdata[53:40];
                    rho_mem[i_s_tdata[5:0]]   = i_s_tdata[66:54];
                end else begin
                    expected_q.push_back(lookup_point(i_s_tdata, i_s_tlast));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '0;
                got.vp        = i_m_tdata[13:0];
                got.vs        = i_m_tdata[27:14];
                got.rho       = i_m_tdata[40:28];
                got.filled    = i_m_tdata[41];
                got.point_gap = i_m_tdata[42];
                got.batch_gap = i_m_tdata[43];
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want !== got) begin
                        $display("%0t: mismatch expected vp=%0d vs=%0d rho=%0d f=%b pg=%b bg=%b",
                                 $realtime, want.vp, want.vs, want.rho, want.filled,
                                 want.point_gap, want.batch_gap);
                        $display("%0t:          actual   vp=%0d vs=%0d rho=%0d f=%b pg=%b bg=%b",
                                 $realtime, got.vp, got.vs, got.rho, got.filled,
                                 got.point_gap, got.batch_gap);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

// ===== test/tb_layered_velocity_profile_lookup.sv =====
// Testbench top for the layered velocity lookup: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb_layered_velocity_profile_lookup;
    import lvpl_pkg::*;

    localparam int  DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 3000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CNT_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    int                errors;
    int                pending;
    int                results;
    bit                quiet;
    bit                tx_gaps;
    int                loads_sent;
    int                queries_sent;
    longint            cycles = 0;

    layered_velocity_profile_lookup DUT (.*);

    lvpl_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stalls in random bursts.
    always @(negedge i_clk) begin
        int stall;
        if (quiet) begin
            stall = 0;
            m_axis_tready <= 1'b1;
        end else if (stall > 0) begin
            stall--;
            m_axis_tready <= (stall > 0) ? 1'b0 : 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(logic op, logic [IN_W-1:0] w, logic last);
        int gap;
        if (tx_gaps && !quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_LOAD) loads_sent++;
        else queries_sent++;
    endtask

    task automatic end_stream();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_layer(logic [5:0] idx, logic [TH_W-1:0] th, logic [V_W-1:0] vp,
                              logic [V_W-1:0] vs, logic [RHO_W-1:0] rho);
        logic [IN_W-1:0] w;
        w = '0;
        w[5:0]   = idx;
        w[25:6]  = th;
        w[39:26] = vp;
        w[53:40] = vs;
        w[66:54] = rho;
        w[108:67] = 42'($urandom()) ^ {$urandom(), 10'h0};  // unused bits toggle
        send_word(OP_LOAD, w, 1'($urandom_range(0, 1)));
    endtask

    task automatic query_point(logic [D_W-1:0] depth, logic [D_W-1:0] shift,
                               logic filled_in, logic in_domain, logic last);
        logic [IN_W-1:0] w;
        w = '0;
        w[66:0]   = 67'({$urandom(), $urandom(), $urandom()});  // don't care on a query
        w[87:67]  = depth;
        w[108:88] = shift;
        w[109]    = filled_in;
        w[110]    = in_domain;
        send_word(OP_QUERY, w, last);
    endtask

    // Config writes only with the block idle.
    task automatic write_cfg(logic idx, logic [CNT_W-1:0] val);
        end_stream();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [TH_W-1:0] rand_thick();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TH_W'($urandom_range(1, 1048575));
            2:       return TH_W'($urandom_range(1, 16));
            default: return TH_W'($urandom_range(1, 40000));
        endcase
    endfunction

    function automatic logic [D_W-1:0] rand_depth();
        case ($urandom_range(0, 7))
            0:       return D_W'($urandom());
            1:       return D_W'($urandom_range(0, 64));
            2:       return D_W'(-$urandom_range(1, 1000));
            default: return D_W'($urandom_range(0, 1600000));
        endcase
    endfunction

    function automatic logic [D_W-1:0] rand_shift();
        case ($urandom_range(0, 5))
            0:       return D_W'($urandom());
            1:       return D_W'($urandom_range(0, 2000) - 1000);
            default: return '0;
        endcase
    endfunction

    task automatic random_items(int count);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0)
                load_layer(6'($urandom()), rand_thick(), 14'($urandom()), 14'($urandom()),
                           13'($urandom()));
            else
                query_point(rand_depth(), rand_shift(), $urandom_range(0, 9) == 0,
                            $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        int k;
        quiet         = 0;
        tx_gaps       = 0;
        loads_sent    = 0;
        queries_sent  = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_LAYER_COUNT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the whole table first so no query ever reads an unwritten entry.
        load_layer(6'd0, 20'hFFFFF, 14'h3FFF, 14'h3FFF, 13'h1FFF);
        load_layer(6'd1, 20'd0, 14'd0, 14'd0, 13'd0);
        for (k = 2; k < MAX_LAYERS; k++)
            load_layer(6'(k), TH_W'($urandom_range(1, 20000)), 14'($urandom()),
                       14'($urandom()), 13'($urandom()));
        load_layer(6'd63, 20'd1, 14'd0, 14'h3FFF, 13'd4096);

        // Directed queries at reset config: single layer, step mode.
        query_point(21'd0, 21'd0, 1'b0, 1'b1, 1'b0);
        query_point(21'h0FFFFF, 21'h0FFFFF, 1'b0, 1'b1, 1'b0);
        query_point(21'h100000, 21'h100000, 1'b0, 1'b1, 1'b1);
        query_point(21'd5, 21'd0, 1'b1, 1'b1, 1'b1);
        query_point(21'd5, 21'd0, 1'b0, 1'b0, 1'b0);
        query_point(21'd5, 21'd0, 1'b1, 1'b0, 1'b1);
        query_point(21'd0, 21'h1FFFFF, 1'b0, 1'b1, 1'b1);

        write_cfg(CFG_LAYER_COUNT, 7'd64);
        write_cfg(CFG_INTERP_MODE, 7'd1);
        load_layer(6'd0, 20'd10, 14'd100, 14'd50, 13'd1000);
        load_layer(6'd1, 20'd0, 14'd0, 14'd0, 13'd0);
        load_layer(6'd2, 20'd7, 14'd16383, 14'd0, 13'd8191);
        query_point(21'd9, 21'd0, 1'b0, 1'b1, 1'b0);
        query_point(21'd10, 21'd0, 1'b0, 1'b1, 1'b0);
        query_point(21'd13, 21'd0, 1'b0, 1'b1, 1'b0);
        query_point(21'd16, 21'd0, 1'b0, 1'b1, 1'b0);
        query_point(21'h0FFFFF, 21'h0FFFFF, 1'b0, 1'b1, 1'b1);
        query_point(21'd3, 21'h1FFFFE, 1'b0, 1'b1, 1'b1);

        tx_gaps = 1;
        write_cfg(CFG_LAYER_COUNT, 7'd0);
        random_items(150);
        write_cfg(CFG_LAYER_COUNT, 7'd127);
        random_items(250);
        write_cfg(CFG_LAYER_COUNT, 7'd2);
        random_items(150);
        write_cfg(CFG_INTERP_MODE, 7'd0);
        random_items(200);
        write_cfg(CFG_LAYER_COUNT, 7'd64);
        random_items(250);
        write_cfg(CFG_INTERP_MODE, 7'd1);
        write_cfg(CFG_LAYER_COUNT, 7'd63);
        random_items(250);
        for (k = 0; k < 3; k++) begin
            write_cfg(CFG_LAYER_COUNT, 7'($urandom_range(1, 70)));
            write_cfg(CFG_INTERP_MODE, 7'($urandom_range(0, 1)));
            random_items(120);
        end
        write_cfg(CFG_LAYER_COUNT, 7'd64);
        quiet = 1;
        random_items(200);
        end_stream();

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("covered %0d layer loads and %0d queries, %0d result words checked",
                 loads_sent, queries_sent, results);
        $display("configs swept: layer counts 0..127 incl. saturation, step and linear modes");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
